FILE: sv/owtr_pkg.sv
`timescale 1ns / 1ps

package owtr_pkg;

    // Register indexes on the configuration port (byte address is 4 * index).
    localparam logic [2:0] REG_RESET_LOW     = 3'd0;
    localparam logic [2:0] REG_PRES_TIMEOUT  = 3'd1;
    localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [2:0] REG_SLOT          = 3'd3;
    localparam logic [2:0] REG_CONV_WAIT     = 3'd4;
    localparam int unsigned ADDR_W           = 5;

    localparam logic [9:0]  RST_RESET_LOW    = 10'd750;
    localparam logic [7:0]  RST_PRES_TIMEOUT = 8'd240;
    localparam logic [9:0]  RST_RESET_TAIL   = 10'd500;
    localparam logic [7:0]  RST_SLOT         = 8'd60;
    localparam logic [19:0] RST_CONV_WAIT    = 20'd750000;

    // Bus commands.
    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_CONVERT   = 8'h44;
    localparam logic [7:0] CMD_READ_PAD  = 8'hBE;

    // Steps of the fixed read sequence.
    localparam logic [3:0] STEP_RESET1    = 4'd0;
    localparam logic [3:0] STEP_SKIP1     = 4'd1;
    localparam logic [3:0] STEP_CONVERT   = 4'd2;
    localparam logic [3:0] STEP_CONV_WAIT = 4'd3;
    localparam logic [3:0] STEP_RESET2    = 4'd4;
    localparam logic [3:0] STEP_SKIP2     = 4'd5;
    localparam logic [3:0] STEP_READ_CMD  = 4'd6;
    localparam logic [3:0] STEP_READ_LSB  = 4'd7;
    localparam logic [3:0] STEP_READ_MSB  = 4'd8;

    localparam logic [19:0] GAP_US = 20'd15;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_RLOW  = 4'd1,
        PH_RGAP  = 4'd2,
        PH_PW1   = 4'd3,
        PH_PW2   = 4'd4,
        PH_TAIL  = 4'd5,
        PH_WSLOT = 4'd6,
        PH_RSLOT = 4'd7,
        PH_RPAD  = 4'd8,
        PH_CONV  = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_PRESENCE = 2'd1,
        ST_STUCK_LOW   = 2'd2
    } t_status;

    typedef struct packed {
        logic kind;
        logic line_level;
    } t_in_word;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic signed [11:0] temperature;
        t_status           status;
    } t_out_word;

    typedef struct packed {
        logic [9:0]  reset_low_us;
        logic [7:0]  presence_timeout_us;
        logic [9:0]  reset_tail_us;
        logic [7:0]  slot_us;
        logic [19:0] conversion_wait_us;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  step;
        logic [19:0] tc;
        logic [2:0]  bit_idx;
        logic [7:0]  shift;
        logic [7:0]  low;
        t_status     err;
    } t_core;

endpackage

FILE: sv/owtr_cfg.sv
`timescale 1ns / 1ps

module owtr_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [owtr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output owtr_pkg::t_cfg              o_cfg
);

    owtr_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_us        <= owtr_pkg::RST_RESET_LOW;
            r_cfg.presence_timeout_us <= owtr_pkg::RST_PRES_TIMEOUT;
            r_cfg.reset_tail_us       <= owtr_pkg::RST_RESET_TAIL;
            r_cfg.slot_us             <= owtr_pkg::RST_SLOT;
            r_cfg.conversion_wait_us  <= owtr_pkg::RST_CONV_WAIT;
        end else if (wr_en) begin
            case (reg_idx)
                owtr_pkg::REG_RESET_LOW:    r_cfg.reset_low_us        <= pwdata[9:0];
                owtr_pkg::REG_PRES_TIMEOUT: r_cfg.presence_timeout_us <= pwdata[7:0];
                owtr_pkg::REG_RESET_TAIL:   r_cfg.reset_tail_us       <= pwdata[9:0];
                owtr_pkg::REG_SLOT:         r_cfg.slot_us             <= pwdata[7:0];
                owtr_pkg::REG_CONV_WAIT:    r_cfg.conversion_wait_us  <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            owtr_pkg::REG_RESET_LOW:    prdata = {22'd0, r_cfg.reset_low_us};
            owtr_pkg::REG_PRES_TIMEOUT: prdata = {24'd0, r_cfg.presence_timeout_us};
            owtr_pkg::REG_RESET_TAIL:   prdata = {22'd0, r_cfg.reset_tail_us};
            owtr_pkg::REG_SLOT:         prdata = {24'd0, r_cfg.slot_us};
            owtr_pkg::REG_CONV_WAIT:    prdata = {12'd0, r_cfg.conversion_wait_us};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

FILE: sv/owtr_ctrl.sv
`timescale 1ns / 1ps

module owtr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  owtr_pkg::t_in_word  i_word,
    input  owtr_pkg::t_cfg      i_cfg,
    output owtr_pkg::t_out_word o_res
);

    owtr_pkg::t_core r_st;
    owtr_pkg::t_core n_st;

    logic              [19:0] tc_inc;
    logic              [20:0] slot_data_end;
    logic              [20:0] slot_end;
    logic                     slot_done;
    logic                     cur_drive;
    logic                     drive;
    logic                     done;
    logic signed       [15:0] word16;
    logic signed       [11:0] temp_sat;
    logic signed       [11:0] temp;
    owtr_pkg::t_status        stat;

    // Sets up the phase for the current step; a zero conversion wait skips that step.
    function automatic owtr_pkg::t_core f_enter(input owtr_pkg::t_core s_in,
                                                input owtr_pkg::t_cfg c);
        owtr_pkg::t_core s;
        s = s_in;
        if (s.step == owtr_pkg::STEP_CONV_WAIT && c.conversion_wait_us == 20'd0) begin
            s.step = owtr_pkg::STEP_RESET2;
        end
        case (s.step)
            owtr_pkg::STEP_RESET1, owtr_pkg::STEP_RESET2: begin
                s.tc    = 20'd0;
                s.phase = (c.reset_low_us == 10'd0) ? owtr_pkg::PH_RGAP : owtr_pkg::PH_RLOW;
            end
            owtr_pkg::STEP_SKIP1, owtr_pkg::STEP_SKIP2: begin
                s.phase = owtr_pkg::PH_WSLOT; s.tc = 20'd0; s.bit_idx = 3'd0;
                s.shift = owtr_pkg::CMD_SKIP_ROM;
            end
            owtr_pkg::STEP_CONVERT: begin
                s.phase = owtr_pkg::PH_WSLOT; s.tc = 20'd0; s.bit_idx = 3'd0;
                s.shift = owtr_pkg::CMD_CONVERT;
            end
            owtr_pkg::STEP_READ_CMD: begin
                s.phase = owtr_pkg::PH_WSLOT; s.tc = 20'd0; s.bit_idx = 3'd0;
                s.shift = owtr_pkg::CMD_READ_PAD;
            end
            owtr_pkg::STEP_CONV_WAIT: begin
                s.phase = owtr_pkg::PH_CONV; s.tc = 20'd0;
            end
            owtr_pkg::STEP_READ_LSB, owtr_pkg::STEP_READ_MSB: begin
                s.phase = owtr_pkg::PH_RSLOT; s.tc = 20'd0; s.bit_idx = 3'd0;
                s.shift = 8'd0;
            end
            default: begin
                s.phase = owtr_pkg::PH_IDLE; s.step = owtr_pkg::STEP_RESET1;
            end
        endcase
        return s;
    endfunction

    function automatic owtr_pkg::t_core f_next(input owtr_pkg::t_core s_in,
                                               input owtr_pkg::t_cfg c);
        owtr_pkg::t_core s;
        s      = s_in;
        s.step = s.step + 4'd1;
        return f_enter(s, c);
    endfunction

    // Only the first error of a sequence is kept; the sequence carries on.
    function automatic owtr_pkg::t_core f_error(input owtr_pkg::t_core s_in,
                                                input owtr_pkg::t_status code,
                                                input owtr_pkg::t_cfg c);
        owtr_pkg::t_core s;
        s = s_in;
        if (s.err == owtr_pkg::ST_OK) begin
            s.err = code;
        end
        return f_next(s, c);
    endfunction

    assign tc_inc        = r_st.tc + 20'd1;
    assign slot_data_end = 21'(i_cfg.slot_us) + 21'd2;
    assign slot_end      = 21'(i_cfg.slot_us) + 21'd4;
    assign slot_done     = {1'b0, tc_inc} >= slot_end;

    always_comb begin
        case (r_st.phase)
            owtr_pkg::PH_RLOW:  cur_drive = 1'b1;
            owtr_pkg::PH_WSLOT: begin
                if (r_st.tc < 20'd2) begin
                    cur_drive = 1'b1;
                end else if ({1'b0, r_st.tc} < slot_data_end) begin
                    cur_drive = !r_st.shift[r_st.bit_idx];
                end else begin
                    cur_drive = 1'b0;
                end
            end
            owtr_pkg::PH_RSLOT: cur_drive = (r_st.tc < 20'd2);
            default:            cur_drive = 1'b0;
        endcase
    end

    // Saturate the 16-bit two's complement reading to the 12-bit result.
    assign word16 = {r_st.shift, r_st.low};
    always_comb begin
        if (!word16[15] && word16[14:11] != 4'b0000) begin
            temp_sat = 12'sd2047;
        end else if (word16[15] && word16[14:11] != 4'b1111) begin
            temp_sat = -12'sd2048;
        end else begin
            temp_sat = word16[11:0];
        end
    end

    always_comb begin
        n_st  = r_st;
        drive = 1'b0;
        done  = 1'b0;
        temp  = 12'sd0;
        stat  = owtr_pkg::ST_OK;
        if (i_push) begin
            if (i_word.kind) begin
                if (r_st.phase == owtr_pkg::PH_IDLE) begin
                    n_st.err  = owtr_pkg::ST_OK;
                    n_st.low  = 8'd0;
                    n_st.step = owtr_pkg::STEP_RESET1;
                    n_st      = f_enter(n_st, i_cfg);
                end else begin
                    drive = cur_drive;
                end
            end else if (r_st.phase != owtr_pkg::PH_IDLE) begin
                drive   = cur_drive;
                n_st.tc = tc_inc;
                case (r_st.phase)
                    owtr_pkg::PH_RLOW: begin
                        if (tc_inc >= 20'(i_cfg.reset_low_us)) begin
                            n_st.phase = owtr_pkg::PH_RGAP; n_st.tc = 20'd0;
                        end
                    end
                    owtr_pkg::PH_RGAP: begin
                        if (tc_inc >= owtr_pkg::GAP_US) begin
                            n_st.phase = owtr_pkg::PH_PW1; n_st.tc = 20'd0;
                        end
                    end
                    owtr_pkg::PH_PW1: begin
                        if (i_cfg.presence_timeout_us == 8'd0) begin
                            n_st = f_error(n_st, owtr_pkg::ST_NO_PRESENCE, i_cfg);
                        end else if (i_word.line_level) begin
                            if (tc_inc >= 20'(i_cfg.presence_timeout_us)) begin
                                n_st = f_error(n_st, owtr_pkg::ST_NO_PRESENCE, i_cfg);
                            end
                        end else begin
                            // The first low tick already counts toward wait two.
                            n_st.phase = owtr_pkg::PH_PW2;
                            n_st.tc    = 20'd1;
                            if (i_cfg.presence_timeout_us == 8'd1) begin
                                n_st = f_error(n_st, owtr_pkg::ST_STUCK_LOW, i_cfg);
                            end
                        end
                    end
                    owtr_pkg::PH_PW2: begin
                        if (!i_word.line_level) begin
                            if (tc_inc >= 20'(i_cfg.presence_timeout_us)) begin
                                n_st = f_error(n_st, owtr_pkg::ST_STUCK_LOW, i_cfg);
                            end
                        end else if (i_cfg.reset_tail_us == 10'd0) begin
                            n_st = f_next(n_st, i_cfg);
                        end else begin
                            n_st.phase = owtr_pkg::PH_TAIL; n_st.tc = 20'd0;
                        end
                    end
                    owtr_pkg::PH_TAIL: begin
                        if (tc_inc >= 20'(i_cfg.reset_tail_us)) begin
                            n_st = f_next(n_st, i_cfg);
                        end
                    end
                    owtr_pkg::PH_CONV: begin
                        if (tc_inc >= i_cfg.conversion_wait_us) begin
                            n_st = f_next(n_st, i_cfg);
                        end
                    end
                    owtr_pkg::PH_WSLOT: begin
                        if (slot_done) begin
                            n_st.tc = 20'd0;
                            if (r_st.bit_idx == 3'd7) begin
                                n_st = f_next(n_st, i_cfg);
                            end else begin
                                n_st.bit_idx = r_st.bit_idx + 3'd1;
                            end
                        end
                    end
                    owtr_pkg::PH_RSLOT: begin
                        if (tc_inc == 20'd3) begin
                            n_st.shift = {i_word.line_level, r_st.shift[7:1]};
                        end
                        if (slot_done) begin
                            n_st.tc = 20'd0;
                            if (r_st.bit_idx == 3'd7) begin
                                n_st.phase = owtr_pkg::PH_RPAD;
                            end else begin
                                n_st.bit_idx = r_st.bit_idx + 3'd1;
                            end
                        end
                    end
                    owtr_pkg::PH_RPAD: begin
                        if (r_st.step == owtr_pkg::STEP_READ_LSB) begin
                            n_st.low = r_st.shift;
                            n_st     = f_next(n_st, i_cfg);
                        end else begin
                            done       = 1'b1;
                            temp       = temp_sat;
                            stat       = r_st.err;
                            n_st.phase = owtr_pkg::PH_IDLE;
                            n_st.step  = owtr_pkg::STEP_RESET1;
                            n_st.tc    = 20'd0;
                        end
                    end
                    default: begin
                        n_st.phase = owtr_pkg::PH_IDLE;
                        n_st.step  = owtr_pkg::STEP_RESET1;
                        n_st.tc    = 20'd0;
                    end
                endcase
            end
        end
        o_res.drive_low   = drive;
        o_res.busy_res    = (n_st.phase != owtr_pkg::PH_IDLE);
        o_res.done_res    = done;
        o_res.temperature = temp;
        o_res.status      = stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase   <= owtr_pkg::PH_IDLE;
            r_st.step    <= owtr_pkg::STEP_RESET1;
            r_st.tc      <= 20'd0;
            r_st.bit_idx <= 3'd0;
            r_st.shift   <= 8'd0;
            r_st.low     <= 8'd0;
            r_st.err     <= owtr_pkg::ST_OK;
        end else begin
            r_st <= n_st;
        end
    end

endmodule

FILE: sv/owtr_obuf.sv
`timescale 1ns / 1ps

module owtr_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  owtr_pkg::t_out_word i_word,
    input  logic                i_stall,
    output logic                o_valid,
    output owtr_pkg::t_out_word o_word,
    output logic                o_full
);

    logic                r_out_valid;
    logic                r_skid_valid;
    owtr_pkg::t_out_word r_out_word;
    owtr_pkg::t_out_word r_skid_word;
    logic                take;

    assign take    = r_out_valid && !i_stall;
    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;
    // The skid stage holding a word is what stalls the input side.
    assign o_full  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out_word <= r_skid_word;
            end
        end else if (i_push) begin
            if (r_out_valid && !take) begin
                r_skid_word <= i_word;
            end else begin
                r_out_word <= i_word;
            end
        end
    end

endmodule

FILE: sv/one_wire_temperature_reader_unit.sv
`timescale 1ns / 1ps

// One-wire bus master that runs a fixed temperature read.
// Input channel: one word per microsecond tick (kind 0, with the sampled line
// level) or a start request (kind 1, ignored while a read is in progress).
// Output channel: exactly one result word per input word, carrying the line
// drive for that tick, the busy flag, and on the completing tick the done
// flag, the 12-bit signed temperature in sixteenths of a degree and the first
// presence error of the sequence.
// Each accepted input word's result is computed combinationally from the
// controller state and the word and registered for the output; one word per
// cycle is sustained while the receiver does not stall. When the receiver
// stalls, a skid stage takes one more word and the input side then stalls
// until the output drains. Reset returns the controller to idle and loads
// the timing registers with their defaults; the user is to write them over the
// APB port only while the block is idle, which the block does not enforce.
module one_wire_temperature_reader_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  owtr_pkg::t_in_word          i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output owtr_pkg::t_out_word         o_out_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [owtr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    owtr_pkg::t_cfg      cfg;
    owtr_pkg::t_out_word res;
    logic                push;
    logic                full;

    assign pready     = 1'b1;
    assign o_in_stall = full;
    assign push       = i_in_valid && !full;

    owtr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    owtr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (i_in_word),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    owtr_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .o_full  (full)
    );

    a_stall_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled while the output register is empty");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted word produced no result");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.done_res) |-> !o_out_word.busy_res)
        else $error("completing result still marked busy");

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.done_res) |->
            (o_out_word.temperature == 12'sd0 && o_out_word.status == owtr_pkg::ST_OK))
        else $error("temperature or status set outside a completing result");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef struct packed {
        logic                kind;
        logic                line_level;
        logic [4:0]          repeats;
        logic                typed;
        owtr_pkg::t_out_word reading;
    } t_probe;

    localparam owtr_pkg::t_out_word QUIET = '{drive_low: 1'b0, busy_res: 1'b0,
                                              done_res: 1'b0, temperature: 12'sd0,
                                              status: owtr_pkg::ST_OK};
    localparam owtr_pkg::t_out_word BUSY_FREE = '{drive_low: 1'b0, busy_res: 1'b1,
                                                  done_res: 1'b0, temperature: 12'sd0,
                                                  status: owtr_pkg::ST_OK};
    localparam owtr_pkg::t_out_word BUSY_LOW = '{drive_low: 1'b1, busy_res: 1'b1,
                                                 done_res: 1'b0, temperature: 12'sd0,
                                                 status: owtr_pkg::ST_OK};

    // Run with a 3 us reset pulse and a presence limit of 12 us.
    localparam int N_PROBES = 11;
    localparam t_probe PROBES [N_PROBES] = '{
        '{KIND_TICK,  1'b0, 5'd1,  1'b1, QUIET},
        '{KIND_TICK,  1'b1, 5'd1,  1'b1, QUIET},
        '{KIND_START, 1'b1, 5'd1,  1'b1, BUSY_FREE},
        '{KIND_TICK,  1'b0, 5'd1,  1'b1, BUSY_LOW},
        '{KIND_START, 1'b0, 5'd1,  1'b1, BUSY_LOW},
        '{KIND_TICK,  1'b1, 5'd2,  1'b1, BUSY_LOW},
        '{KIND_TICK,  1'b1, 5'd15, 1'b1, BUSY_FREE},
        '{KIND_TICK,  1'b0, 5'd1,  1'b0, QUIET},
        '{KIND_TICK,  1'b0, 5'd2,  1'b0, QUIET},
        '{KIND_START, 1'b1, 5'd1,  1'b1, BUSY_FREE},
        '{KIND_TICK,  1'b1, 5'd1,  1'b0, QUIET}
    };

    localparam int N_TIMINGS = 5;
    localparam owtr_pkg::t_cfg TIMING_PLAN [N_TIMINGS] = '{
        '{10'd3,    8'd12,  10'd4,    8'd2,   20'd9},
        '{10'd1,    8'd0,   10'd0,    8'd0,   20'd0},
        '{10'd0,    8'd1,   10'd0,    8'd1,   20'd0},
        '{10'd2,    8'd8,   10'd2,    8'd1,   20'd3},
        '{10'd2,    8'd255, 10'd3,    8'd255, 20'd1048575}
    };

    localparam logic [15:0] EDGE_READINGS [8] = '{
        16'h07FF, 16'h0800, 16'hF800, 16'hF7FF, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    owtr_pkg::t_in_word          i_in_word = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    owtr_pkg::t_out_word         o_out_word;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [owtr_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // Mirror of the bus master's timing registers and sequencer.
    owtr_pkg::t_cfg    timing;
    owtr_pkg::t_phase  rd_phase;
    logic [3:0]        rd_step;
    logic [19:0]       rd_count;
    logic [2:0]        rd_bit;
    logic [7:0]        rd_shift;
    logic [7:0]        rd_low;
    owtr_pkg::t_status rd_err;

    // Word the simulated sensor sends back during the current read.
    logic [15:0] sensor_word = '0;

    owtr_pkg::t_out_word due_words [$];
    int                  fail_count = 0;
    int                  hold_cycles = 0;
    int                  reads_done = 0;
    bit                  send_steady = 1'b0;
    bit                  take_steady = 1'b0;

    one_wire_temperature_reader_unit uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void load_command(logic [7:0] cmd);
        rd_phase = owtr_pkg::PH_WSLOT;
        rd_count = '0;
        rd_bit   = '0;
        rd_shift = cmd;
    endfunction

    function automatic void enter_step();
        if (rd_step == owtr_pkg::STEP_CONV_WAIT && timing.conversion_wait_us == '0)
            rd_step = owtr_pkg::STEP_RESET2;
        case (rd_step)
            owtr_pkg::STEP_RESET1, owtr_pkg::STEP_RESET2: begin
                rd_count = '0;
                rd_phase = (timing.reset_low_us == '0) ? owtr_pkg::PH_RGAP
                                                       : owtr_pkg::PH_RLOW;
            end
            owtr_pkg::STEP_SKIP1, owtr_pkg::STEP_SKIP2: load_command(owtr_pkg::CMD_SKIP_ROM);
            owtr_pkg::STEP_CONVERT:  load_command(owtr_pkg::CMD_CONVERT);
            owtr_pkg::STEP_READ_CMD: load_command(owtr_pkg::CMD_READ_PAD);
            owtr_pkg::STEP_CONV_WAIT: begin
                rd_phase = owtr_pkg::PH_CONV;
                rd_count = '0;
            end
            owtr_pkg::STEP_READ_LSB, owtr_pkg::STEP_READ_MSB: begin
                rd_phase = owtr_pkg::PH_RSLOT;
                rd_count = '0;
                rd_bit   = '0;
                rd_shift = '0;
            end
            default: begin
                rd_phase = owtr_pkg::PH_IDLE;
                rd_step  = owtr_pkg::STEP_RESET1;
            end
        endcase
    endfunction

    function automatic void next_step();
        rd_step = rd_step + 4'd1;
        enter_step();
    endfunction

    function automatic void raise_error(owtr_pkg::t_status code);
        if (rd_err == owtr_pkg::ST_OK) rd_err = code;
        next_step();
    endfunction

    function automatic logic line_drive();
        case (rd_phase)
            owtr_pkg::PH_RLOW:  return 1'b1;
            owtr_pkg::PH_WSLOT: begin
                if (rd_count < 2) return 1'b1;
                if (rd_count < 2 + timing.slot_us) return ~rd_shift[rd_bit];
                return 1'b0;
            end
            owtr_pkg::PH_RSLOT: return rd_count < 2;
            default:            return 1'b0;
        endcase
    endfunction

    function automatic owtr_pkg::t_out_word reader_tick(owtr_pkg::t_in_word w);
        owtr_pkg::t_out_word r;
        logic signed [15:0]  raw;
        r = '0;
        if (w.kind == KIND_START) begin
            if (rd_phase == owtr_pkg::PH_IDLE) begin
                rd_err  = owtr_pkg::ST_OK;
                rd_low  = '0;
                rd_step = owtr_pkg::STEP_RESET1;
                enter_step();
            end else begin
                r.drive_low = line_drive();
            end
        end else if (rd_phase != owtr_pkg::PH_IDLE) begin
            r.drive_low = line_drive();
            rd_count = rd_count + 20'd1;
            case (rd_phase)
                owtr_pkg::PH_RLOW: begin
                    if (rd_count >= timing.reset_low_us) begin
                        rd_phase = owtr_pkg::PH_RGAP;
                        rd_count = '0;
                    end
                end
                owtr_pkg::PH_RGAP: begin
                    if (rd_count >= owtr_pkg::GAP_US) begin
                        rd_phase = owtr_pkg::PH_PW1;
                        rd_count = '0;
                    end
                end
                owtr_pkg::PH_PW1: begin
                    if (timing.presence_timeout_us == '0) begin
                        raise_error(owtr_pkg::ST_NO_PRESENCE);
                    end else if (w.line_level) begin
                        if (rd_count >= timing.presence_timeout_us)
                            raise_error(owtr_pkg::ST_NO_PRESENCE);
                    end else begin
                        // The falling edge already counts as the first low tick.
                        rd_phase = owtr_pkg::PH_PW2;
                        rd_count = 20'd1;
                        if (rd_count >= timing.presence_timeout_us)
                            raise_error(owtr_pkg::ST_STUCK_LOW);
                    end
                end
                owtr_pkg::PH_PW2: begin
                    if (!w.line_level) begin
                        if (rd_count >= timing.presence_timeout_us)
                            raise_error(owtr_pkg::ST_STUCK_LOW);
                    end else if (timing.reset_tail_us == '0) begin
                        next_step();
                    end else begin
                        rd_phase = owtr_pkg::PH_TAIL;
                        rd_count = '0;
                    end
                end
                owtr_pkg::PH_TAIL: begin
                    if (rd_count >= timing.reset_tail_us) next_step();
                end
                owtr_pkg::PH_CONV: begin
                    if (rd_count >= timing.conversion_wait_us) next_step();
                end
                owtr_pkg::PH_WSLOT: begin
                    if (rd_count >= 4 + timing.slot_us) begin
                        rd_count = '0;
                        if (rd_bit == 3'd7) next_step();
                        else rd_bit = rd_bit + 3'd1;
                    end
                end
                owtr_pkg::PH_RSLOT: begin
                    if (rd_count == 20'd3) rd_shift = {w.line_level, rd_shift[7:1]};
                    if (rd_count >= 4 + timing.slot_us) begin
                        rd_count = '0;
                        if (rd_bit == 3'd7) rd_phase = owtr_pkg::PH_RPAD;
                        else rd_bit = rd_bit + 3'd1;
                    end
                end
                owtr_pkg::PH_RPAD: begin
                    if (rd_step == owtr_pkg::STEP_READ_LSB) begin
                        rd_low = rd_shift;
                        next_step();
                    end else begin
                        raw = {rd_shift, rd_low};
                        r.done_res = 1'b1;
                        if (raw > 16'sd2047) r.temperature = 12'sh7FF;
                        else if (raw < -16'sd2048) r.temperature = 12'sh800;
                        else r.temperature = raw[11:0];
                        r.status = rd_err;
                        rd_phase = owtr_pkg::PH_IDLE;
                        rd_step  = owtr_pkg::STEP_RESET1;
                        rd_count = '0;
                    end
                end
                default: begin
                    rd_phase = owtr_pkg::PH_IDLE;
                    rd_step  = owtr_pkg::STEP_RESET1;
                    rd_count = '0;
                end
            endcase
        end
        r.busy_res = (rd_phase != owtr_pkg::PH_IDLE);
        return r;
    endfunction

    // Plays the sensor: answers presence, returns sensor_word in read slots, and
    // otherwise puts noise on the line. Starts come mostly while idle.
    function automatic owtr_pkg::t_in_word pick_word();
        owtr_pkg::t_in_word w;
        w.kind       = KIND_TICK;
        w.line_level = 1'($urandom);
        if (rd_phase == owtr_pkg::PH_IDLE) begin
            if ($urandom_range(0, 3) != 0) begin
                w.kind = KIND_START;
                case ($urandom_range(0, 3))
                    0:       sensor_word = 16'($urandom);
                    1:       sensor_word = EDGE_READINGS[$urandom_range(0, 7)];
                    default: sensor_word = 16'($urandom_range(0, 4095) - 2048);
                endcase
            end
        end else if ($urandom_range(0, 31) == 0) begin
            w.kind = KIND_START;
        end else begin
            case (rd_phase)
                owtr_pkg::PH_PW1:   w.line_level = ($urandom_range(0, 3) != 0);
                owtr_pkg::PH_PW2:   w.line_level = ($urandom_range(0, 2) == 0);
                owtr_pkg::PH_RSLOT: begin
                    if (rd_count == 20'd2)
                        w.line_level =
                            sensor_word[{rd_step == owtr_pkg::STEP_READ_MSB, rd_bit}];
                end
                default: ;
            endcase
        end
        return w;
    endfunction

    task automatic send_word(owtr_pkg::t_in_word w, logic typed,
                             owtr_pkg::t_out_word typed_word);
        int                  gap;
        owtr_pkg::t_out_word predicted;
        gap = send_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = reader_tick(w);
        if (predicted.done_res) reads_done++;
        due_words.push_back(typed ? typed_word : predicted);
    endtask

    task automatic write_register(logic [2:0] index, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_timing(owtr_pkg::t_cfg c);
        write_register(owtr_pkg::REG_RESET_LOW,    32'(c.reset_low_us));
        write_register(owtr_pkg::REG_PRES_TIMEOUT, 32'(c.presence_timeout_us));
        write_register(owtr_pkg::REG_RESET_TAIL,   32'(c.reset_tail_us));
        write_register(owtr_pkg::REG_SLOT,         32'(c.slot_us));
        write_register(owtr_pkg::REG_CONV_WAIT,    32'(c.conversion_wait_us));
        timing = c;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : take_results
        int                  wait_cycles;
        int                  taken;
        owtr_pkg::t_out_word due;
        taken = 0;
        forever begin
            wait_cycles = take_steady ? 0 : $urandom_range(0, 3);
            if (hold_cycles > 0) begin
                wait_cycles = hold_cycles;
                hold_cycles = 0;
            end
            if (wait_cycles > 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (wait_cycles - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            if (due_words.size() == 0) begin
                $error("result word %h arrived with nothing expected", o_out_word);
                fail_count++;
            end else begin
                due = due_words.pop_front();
                if (o_out_word.drive_low !== due.drive_low) begin
                    $error("drive_low: expected %0d, got %0d",
                           due.drive_low, o_out_word.drive_low);
                    fail_count++;
                end
                if (o_out_word.busy_res !== due.busy_res) begin
                    $error("busy_res: expected %0d, got %0d",
                           due.busy_res, o_out_word.busy_res);
                    fail_count++;
                end
                if (o_out_word.done_res !== due.done_res) begin
                    $error("done_res: expected %0d, got %0d",
                           due.done_res, o_out_word.done_res);
                    fail_count++;
                end
                if (o_out_word.temperature !== due.temperature) begin
                    $error("temperature: expected %0d, got %0d",
                           due.temperature, o_out_word.temperature);
                    fail_count++;
                end
                if (o_out_word.status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, o_out_word.status);
                    fail_count++;
                end
            end
            taken++;
            if (taken % 64 == 0) take_steady = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin : run_reads
        owtr_pkg::t_in_word probe;
        owtr_pkg::t_cfg     cfg;
        int                 sent;
        bit                 last_plan;
        timing   = '{owtr_pkg::RST_RESET_LOW, owtr_pkg::RST_PRES_TIMEOUT,
                     owtr_pkg::RST_RESET_TAIL, owtr_pkg::RST_SLOT,
                     owtr_pkg::RST_CONV_WAIT};
        rd_phase = owtr_pkg::PH_IDLE;
        rd_step  = owtr_pkg::STEP_RESET1;
        rd_count = '0;
        rd_bit   = '0;
        rd_shift = '0;
        rd_low   = '0;
        rd_err   = owtr_pkg::ST_OK;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int s = 0; s < N_TIMINGS; s++) begin
            cfg = TIMING_PLAN[s];
            if (s == 3) begin
                cfg.reset_low_us        = 10'($urandom_range(0, 8));
                cfg.presence_timeout_us = 8'($urandom_range(0, 30));
                cfg.reset_tail_us       = 10'($urandom_range(0, 8));
                cfg.slot_us             = 8'($urandom_range(0, 2));
                cfg.conversion_wait_us  = 20'($urandom_range(0, 20));
            end
            drain();
            set_timing(cfg);
            if (s == 0) begin
                // The receiver sits out a long stretch so the block backs up.
                hold_cycles = 200;
                foreach (PROBES[p]) begin
                    repeat (PROBES[p].repeats) begin
                        probe.kind       = PROBES[p].kind;
                        probe.line_level = PROBES[p].line_level;
                        send_word(probe, PROBES[p].typed, PROBES[p].reading);
                    end
                end
            end
            // Every timing but the last gets one complete read. The last one has the
            // widest slot and only runs into the first write slot.
            last_plan  = (s == N_TIMINGS - 1);
            reads_done = 0;
            sent       = 0;
            while (last_plan ? (sent < 100) : (sent < 40 || reads_done == 0)) begin
                send_word(pick_word(), 1'b0, QUIET);
                sent++;
                if (sent % 64 == 0) send_steady = ($urandom_range(0, 3) == 0);
            end
            if (!last_plan) begin
                while (rd_phase != owtr_pkg::PH_IDLE) send_word(pick_word(), 1'b0, QUIET);
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("one_wire_temperature_reader_unit test passed");
        end else begin
            $display("one_wire_temperature_reader_unit test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("one_wire_temperature_reader_unit test failed");
        $finish;
    end

endmodule
